@@ hw/rtl/udpdmx_pkg.sv @@
`default_nettype none
//------------------------------------------------------------------------------
// udpdmx_pkg: shared types and constants for the UDP port demux queue
// Command codes, status codes, header constants and the word that travels
// from the classify front end to the execute back end.
//------------------------------------------------------------------------------
package udpdmx_pkg;

  // default sizing
  localparam int NUM_PORTS_DEF   = 256;
  localparam int QUEUE_DEPTH_DEF = 16;

  // depth of the queue between front end and back end (power of two)
  localparam int FQ_DEPTH = 2;

  // width of the queue level result field
  localparam int LEVEL_W = 5;

  // header constants
  localparam logic [15:0] ETH_HDR_END = 16'd14;
  localparam logic [15:0] IP_HDR_END  = 16'd34;
  localparam logic [15:0] UDP_HDR_END = 16'd42;
  localparam logic [15:0] UDP_HDR_LEN = 16'd8;
  localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [3:0]  IP_VER4     = 4'd4;

  // command codes on the input channel
  localparam logic [1:0] CMD_RECV = 2'd0;
  localparam logic [1:0] CMD_BIND = 2'd1;
  localparam logic [1:0] CMD_DEQ  = 2'd2;

  typedef enum logic [1:0] {
    OP_RECV,
    OP_BIND,
    OP_DEQ,
    OP_NOP
  } op_t;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_SHORT    = 4'd1,
    ST_NOT_IP   = 4'd2,
    ST_BAD_VER  = 4'd3,
    ST_NOT_UDP  = 4'd4,
    ST_UNBOUND  = 4'd5,
    ST_FULL     = 4'd6,
    ST_BAD_ULEN = 4'd7,
    ST_EMPTY    = 4'd8,
    ST_RANGE    = 4'd9
  } status_t;

  // back end sequencer
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC,
    BK_DESC
  } bk_state_t;

  // classified command word handed from front end to back end
  typedef struct packed {
    op_t         op;
    logic [15:0] port;        // zero when out of range
    logic        in_range;
    status_t     hdr_status;  // header checks and range check, in order
    logic        ulen_ok;
    logic [31:0] sender_ip;
    logic [15:0] sender_port;
    logic [15:0] plen;
    logic [15:0] max_len;
  } item_t;

  // one stored descriptor
  typedef struct packed {
    logic [31:0] sender_ip;
    logic [15:0] sender_port;
    logic [15:0] plen;
  } desc_t;

endpackage : udpdmx_pkg
`default_nettype wire

@@ hw/rtl/udp_port_demux_queue_unit.sv @@
`default_nettype none
// Path: queue, state read, execute, result; a dequeue that finds data adds the descriptor read.
// The back end takes one word at a time, held by out_ready, set by the
//   read-then-write of the port state memory and the registered descriptor read.
// Reset: synchronous, active low; then a clearing pass zeroes every port state entry
//   while in_ready stays low. Descriptors are not cleared.
//------------------------------------------------------------------------------
// udp_port_demux_queue_unit: UDP port demultiplexer with a descriptor FIFO per port
// Receive stores a descriptor (source IP, source port, payload length) in the
// queue of a bound port; bind marks a port; dequeue returns the oldest entry.
// Every command word gives exactly one result word.
//------------------------------------------------------------------------------
module udp_port_demux_queue_unit #(
  parameter int NUM_PORTS   = udpdmx_pkg::NUM_PORTS_DEF,
  parameter int QUEUE_DEPTH = udpdmx_pkg::QUEUE_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  // command channel
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  in_command,
  input  wire  [15:0] in_frame_len,
  input  wire  [15:0] in_ether_type,
  input  wire  [3:0]  in_ip_version,
  input  wire  [7:0]  in_ip_proto,
  input  wire  [15:0] in_port,
  input  wire  [15:0] in_sender_port,
  input  wire  [31:0] in_sender_ip,
  input  wire  [15:0] in_udp_length,
  input  wire  [15:0] in_max_len,
  // result channel
  output logic        out_valid,
  input  wire         out_ready,
  output logic [3:0]  out_status,
  output logic [31:0] out_out_sender_ip,
  output logic [15:0] out_out_sender_port,
  output logic [15:0] out_payload_len,
  output logic [15:0] out_clip_len,
  output logic [4:0]  out_queue_level
);
  import udpdmx_pkg::*;

  logic  clearing;
  logic  q_valid;
  logic  q_pop;
  item_t q_entry;

  // Front end: decode the command and run the header checks that need no
  // port state, then hold the classified word in a two-deep queue so the
  // input side keeps taking words while the back end is busy.
  udpdmx_front #(
    .NUM_PORTS (NUM_PORTS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .clearing       (clearing),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_frame_len   (in_frame_len),
    .in_ether_type  (in_ether_type),
    .in_ip_version  (in_ip_version),
    .in_ip_proto    (in_ip_proto),
    .in_port        (in_port),
    .in_sender_port (in_sender_port),
    .in_sender_ip   (in_sender_ip),
    .in_udp_length  (in_udp_length),
    .in_max_len     (in_max_len),
    .q_valid        (q_valid),
    .q_entry        (q_entry),
    .q_pop          (q_pop)
  );

  // Back end: read the port state word (bound, count, head), apply the
  // command, write it back, and touch the descriptor memory. One word at a
  // time, so each read sees the write of the word before it. The result
  // register holds one result; while it waits unaccepted, the back end holds the
  // next word in execute and writes nothing; a dequeue hit writes its state and waits in the descriptor step.
  udpdmx_back #(
    .NUM_PORTS   (NUM_PORTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .clearing        (clearing),
    .q_valid         (q_valid),
    .q_entry         (q_entry),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_sender_ip   (out_out_sender_ip),
    .out_sender_port (out_out_sender_port),
    .out_payload_len (out_payload_len),
    .out_clip_len    (out_clip_len),
    .out_queue_level (out_queue_level)
  );

  // hold off new words until the port state is cleared
  a_no_accept_while_clearing : assert property (
    @(posedge clk) disable iff (!rst_n) clearing |-> !in_ready
  ) else $error("command accepted during clearing pass");

  // clipped length never exceeds the payload length
  a_clip_le_payload : assert property (
    @(posedge clk) disable iff (!rst_n) out_valid |-> (out_clip_len <= out_payload_len)
  ) else $error("clipped length above payload length");

  // an empty dequeue carries no descriptor
  a_empty_no_desc : assert property (
    @(posedge clk) disable iff (!rst_n)
      (out_valid && (out_status == ST_EMPTY)) |->
        (out_out_sender_ip == 32'd0 && out_clip_len == 16'd0 && out_payload_len == 16'd0)
  ) else $error("empty status with descriptor data");

  // only defined status codes leave the block
  a_status_range : assert property (
    @(posedge clk) disable iff (!rst_n) out_valid |-> (out_status <= ST_RANGE)
  ) else $error("undefined status code");

endmodule : udp_port_demux_queue_unit
`default_nettype wire

@@ hw/rtl/udpdmx_front.sv @@
`default_nettype none
//------------------------------------------------------------------------------
// udpdmx_front: command decode, header classification and hand-off queue
// Decodes the command, runs the stateless header checks in priority order
// and pushes one classified word into a short queue for the back end.
//------------------------------------------------------------------------------
module udpdmx_front #(
  parameter int NUM_PORTS = udpdmx_pkg::NUM_PORTS_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                clearing,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [1:0]         in_command,
  input  wire  [15:0]        in_frame_len,
  input  wire  [15:0]        in_ether_type,
  input  wire  [3:0]         in_ip_version,
  input  wire  [7:0]         in_ip_proto,
  input  wire  [15:0]        in_port,
  input  wire  [15:0]        in_sender_port,
  input  wire  [31:0]        in_sender_ip,
  input  wire  [15:0]        in_udp_length,
  input  wire  [15:0]        in_max_len,
  output logic               q_valid,
  output udpdmx_pkg::item_t  q_entry,
  input  wire                q_pop
);
  import udpdmx_pkg::*;

  localparam int FQ_AW = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
  localparam logic [16:0] PORT_LIMIT = 17'(NUM_PORTS);
  localparam logic [FQ_AW:0] FQ_FULL = (FQ_AW + 1)'(FQ_DEPTH);

  item_t             cls;
  logic              in_range;
  logic              push;

  item_t             fifo_r [FQ_DEPTH];
  logic [FQ_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [FQ_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FQ_AW:0]    cnt_r, cnt_nxt;

  assign in_range = {1'b0, in_port} < PORT_LIMIT;

  // classify
  always_comb begin
    cls             = '0;
    cls.port        = in_range ? in_port : 16'd0;
    cls.in_range    = in_range;
    cls.ulen_ok     = in_udp_length >= UDP_HDR_LEN;
    cls.sender_ip   = in_sender_ip;
    cls.sender_port = in_sender_port;
    cls.plen        = in_udp_length - UDP_HDR_LEN;
    cls.max_len     = in_max_len;
    cls.hdr_status  = ST_OK;
    unique case (in_command)
      CMD_RECV: begin
        cls.op = OP_RECV;
        if (in_frame_len < ETH_HDR_END) cls.hdr_status = ST_SHORT;
        else if (in_ether_type != ETYPE_IPV4) cls.hdr_status = ST_NOT_IP;
        else if (in_frame_len < IP_HDR_END) cls.hdr_status = ST_SHORT;
        else if (in_ip_version != IP_VER4) cls.hdr_status = ST_BAD_VER;
        else if (in_ip_proto != PROTO_UDP) cls.hdr_status = ST_NOT_UDP;
        else if (in_frame_len < UDP_HDR_END) cls.hdr_status = ST_SHORT;
        else if (!in_range) cls.hdr_status = ST_RANGE;
        else cls.hdr_status = ST_OK;
      end
      CMD_BIND: begin
        cls.op         = OP_BIND;
        cls.hdr_status = in_range ? ST_OK : ST_RANGE;
      end
      CMD_DEQ: begin
        cls.op         = OP_DEQ;
        cls.hdr_status = in_range ? ST_OK : ST_RANGE;
      end
      default: begin
        cls.op       = OP_NOP;
        cls.in_range = 1'b0;
      end
    endcase
  end

  // hand-off queue
  assign in_ready = !clearing && (cnt_r != FQ_FULL);
  assign push     = in_valid && in_ready;
  assign q_valid  = cnt_r != '0;
  assign q_entry  = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (FQ_AW + 1)'(push) - (FQ_AW + 1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

endmodule : udpdmx_front
`default_nettype wire

@@ hw/rtl/udpdmx_back.sv @@
`default_nettype none
//------------------------------------------------------------------------------
// udpdmx_back: per-port state and descriptor store sequencer
// Reads the port state, applies bind/enqueue/dequeue, reads the descriptor
// on a dequeue that finds data and loads the result register; after reset it clears the port state.
//------------------------------------------------------------------------------
module udpdmx_back #(
  parameter int NUM_PORTS   = udpdmx_pkg::NUM_PORTS_DEF,
  parameter int QUEUE_DEPTH = udpdmx_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  output logic                clearing,
  input  wire                 q_valid,
  input  udpdmx_pkg::item_t   q_entry,
  output logic                q_pop,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [3:0]          out_status,
  output logic [31:0]         out_sender_ip,
  output logic [15:0]         out_sender_port,
  output logic [15:0]         out_payload_len,
  output logic [15:0]         out_clip_len,
  output logic [udpdmx_pkg::LEVEL_W-1:0] out_queue_level
);
  import udpdmx_pkg::*;

  localparam int PW   = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int HW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SW   = 1 + CW + HW;
  localparam int NDESC = NUM_PORTS * QUEUE_DEPTH;
  localparam int AW   = (NDESC > 1) ? $clog2(NDESC) : 1;
  localparam logic [PW-1:0] LAST_PORT = PW'(NUM_PORTS - 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);
  localparam logic [CW:0]   DEPTH_S   = (CW + 1)'(QUEUE_DEPTH);
  localparam logic [HW-1:0] LAST_SLOT = HW'(QUEUE_DEPTH - 1);
  localparam logic [AW-1:0] DEPTH_A   = AW'(QUEUE_DEPTH);

  bk_state_t state_r, state_nxt;

  // storage
  logic [SW-1:0] st_mem [NUM_PORTS];
  desc_t         desc_mem [NDESC];

  logic [PW-1:0] clr_idx_r;
  logic          clr_last;
  item_t         item_r;
  logic [SW-1:0] st_rd_r;
  desc_t         desc_rd_r;
  logic [CW-1:0] lvl_r;

  // state port
  logic          st_re, st_we;
  logic [PW-1:0] st_raddr, st_waddr;
  logic [SW-1:0] st_wdata;

  // descriptor port
  logic          desc_we, desc_re;
  logic [AW-1:0] desc_addr;
  desc_t         desc_wdata;

  // execute datapath
  logic          st_bound;
  logic [CW-1:0] st_cnt;
  logic [HW-1:0] st_head;
  logic [CW:0]   tail_sum;
  logic [HW-1:0] tail;
  logic [HW-1:0] head_inc;
  logic          full;
  logic          enq_ok, deq_hit;
  logic          new_bound;
  logic [CW-1:0] new_cnt;
  logic [HW-1:0] new_head;
  status_t       ex_status;
  logic [15:0]   ex_plen;
  logic [CW-1:0] ex_level;
  logic [PW-1:0] port_idx;

  logic          out_free, load_out;
  status_t       res_status;
  logic [31:0]   res_ip;
  logic [15:0]   res_sport, res_plen, res_copy;
  logic [CW-1:0] res_level;
  logic [CW+LEVEL_W-1:0] res_level_ext;

  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r;
  logic [31:0]          out_ip_r;
  logic [15:0]          out_sport_r, out_plen_r, out_copy_r;
  logic [LEVEL_W-1:0]   out_level_r;

  assign port_idx = item_r.port[PW-1:0];
  assign clr_last = clr_idx_r == LAST_PORT;
  assign clearing = state_r == BK_CLEAR;
  assign out_free = !out_valid_r || out_ready;

  // execute: decide status and next port state from the read state word
  always_comb begin
    {st_bound, st_cnt, st_head} = st_rd_r;
    tail_sum  = (CW + 1)'(st_head) + (CW + 1)'(st_cnt);
    tail      = (tail_sum >= DEPTH_S) ? HW'(tail_sum - DEPTH_S) : HW'(tail_sum);
    head_inc  = (st_head == LAST_SLOT) ? '0 : st_head + 1'b1;
    full      = st_cnt >= DEPTH_C;
    enq_ok    = 1'b0;
    deq_hit   = 1'b0;
    new_bound = st_bound;
    new_cnt   = st_cnt;
    new_head  = st_head;
    ex_status = ST_OK;
    ex_plen   = 16'd0;
    case (item_r.op)
      OP_RECV: begin
        if (item_r.hdr_status != ST_OK) ex_status = item_r.hdr_status;
        else if (!st_bound) ex_status = ST_UNBOUND;
        else if (full) ex_status = ST_FULL;
        else if (!item_r.ulen_ok) ex_status = ST_BAD_ULEN;
        else begin
          ex_status = ST_OK;
          enq_ok    = 1'b1;
          new_cnt   = st_cnt + 1'b1;
          ex_plen   = item_r.plen;
        end
      end
      OP_BIND: begin
        ex_status = item_r.hdr_status;
        if (item_r.in_range) new_bound = 1'b1;
      end
      OP_DEQ: begin
        if (!item_r.in_range) ex_status = ST_RANGE;
        else if (st_cnt == '0) ex_status = ST_EMPTY;
        else begin
          deq_hit  = 1'b1;
          new_cnt  = st_cnt - 1'b1;
          new_head = head_inc;
        end
      end
      default: ex_status = ST_OK;
    endcase
    ex_level = item_r.in_range ? new_cnt : '0;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_CLEAR: if (clr_last) state_nxt = BK_IDLE;
      BK_IDLE:  if (q_valid) state_nxt = BK_EXEC;
      BK_EXEC: begin
        if (deq_hit) state_nxt = BK_DESC;
        else if (out_free) state_nxt = BK_IDLE;
      end
      BK_DESC:  if (out_free) state_nxt = BK_IDLE;
      default:  state_nxt = BK_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_pop    = 1'b0;
    st_re    = 1'b0;
    st_we    = 1'b0;
    st_waddr = port_idx;
    st_wdata = {new_bound, new_cnt, new_head};
    desc_we  = 1'b0;
    desc_re  = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      BK_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_idx_r;
        st_wdata = '0;
      end
      BK_IDLE: begin
        q_pop = q_valid;
        st_re = q_valid;
      end
      BK_EXEC: begin
        st_we    = deq_hit || out_free;
        desc_we  = enq_ok && out_free;
        desc_re  = deq_hit;
        load_out = !deq_hit && out_free;
      end
      BK_DESC: load_out = out_free;
      default: ;
    endcase
  end

  assign st_raddr   = q_entry.port[PW-1:0];
  assign desc_addr  = AW'(port_idx) * DEPTH_A + AW'(enq_ok ? tail : st_head);
  assign desc_wdata = '{sender_ip: item_r.sender_ip, sender_port: item_r.sender_port,
                        plen: item_r.plen};

  // result select
  always_comb begin
    if (state_r == BK_DESC) begin
      res_status = ST_OK;
      res_ip     = desc_rd_r.sender_ip;
      res_sport  = desc_rd_r.sender_port;
      res_plen   = desc_rd_r.plen;
      res_copy   = (desc_rd_r.plen > item_r.max_len) ? item_r.max_len : desc_rd_r.plen;
      res_level  = lvl_r;
    end else begin
      res_status = ex_status;
      res_ip     = 32'd0;
      res_sport  = 16'd0;
      res_plen   = ex_plen;
      res_copy   = 16'd0;
      res_level  = ex_level;
    end
    res_level_ext = (CW + LEVEL_W)'(res_level);
    out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == BK_CLEAR) clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) item_r <= q_entry;
    if (desc_re) lvl_r <= ex_level;
    if (load_out) begin
      out_status_r <= res_status;
      out_ip_r     <= res_ip;
      out_sport_r  <= res_sport;
      out_plen_r   <= res_plen;
      out_copy_r   <= res_copy;
      out_level_r  <= res_level_ext[LEVEL_W-1:0];
    end
  end

  // port state memory
  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_waddr] <= st_wdata;
    if (st_re) st_rd_r <= st_mem[st_raddr];
  end

  // descriptor memory
  always_ff @(posedge clk) begin
    if (desc_we) desc_mem[desc_addr] <= desc_wdata;
    if (desc_re) desc_rd_r <= desc_mem[desc_addr];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_sender_ip   = out_ip_r;
  assign out_sender_port = out_sport_r;
  assign out_payload_len = out_plen_r;
  assign out_clip_len    = out_copy_r;
  assign out_queue_level = out_level_r;

endmodule : udpdmx_back
`default_nettype wire
